>>> src/fea_pkg.sv
// Shared constants, types and codes for the free extent allocator.
package fea_pkg;

	localparam int MAX_EXTENTS = 82;
	localparam int SECTOR_BITS = 24;
	localparam int CNT_W       = 8;
	localparam int AW          = $clog2(MAX_EXTENTS);
	localparam int ENTRY_W     = 2 * SECTOR_BITS;

	typedef logic [SECTOR_BITS-1:0] sector_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [AW-1:0]          addr_t;
	typedef logic [ENTRY_W-1:0]     entry_t;

	// opcodes
	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_APPEND  = 3'd1;
	localparam logic [2:0] OP_FIND    = 3'd2;
	localparam logic [2:0] OP_OCCUPY  = 3'd3;
	localparam logic [2:0] OP_CLAIM   = 3'd4;
	localparam logic [2:0] OP_RELEASE = 3'd5;
	localparam logic [2:0] OP_READ    = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INDEX   = 2'd3;

	// edit applied at the target entry during a rewrite pass
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_REMOVE,
		ACT_FRONT,
		ACT_BACK,
		ACT_SPLIT,
		ACT_INSERT
	} act_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RWR,
		S_FLUSH,
		S_RESP,
		S_RDENT,
		S_RDWAIT
	} state_t;

endpackage

>>> src/fea_ram.sv
// Generic simple dual-port RAM with registered read.
module fea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/free_extent_allocator_top.sv
// Top level of the free extent allocator: sequencer, scan, rewrite and merge datapath.
//
// Holds up to 82 free extents (start, length) in two RAM banks with registered read.
// One operation is in flight at a time. Find makes one linear scan of the active bank.
// Occupy, claim and release scan to locate the target entry, then a rewrite pass streams
// the active bank through the edit and merge stages into the other bank, which then
// becomes active; occupy with no match and release on a full table skip that pass.
// Clear, append and no-op skip the scan, and read entry reads one entry. The scan and
// rewrite passes are bounded by the single read port per bank. The next operation is
// accepted while the previous result waits in the output register.
module free_extent_allocator_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       opcode,
	input  fea_pkg::sector_t start_sector,
	input  fea_pkg::sector_t sector_count,
	input  logic [7:0]       entry_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output fea_pkg::sector_t found_start,
	output fea_pkg::sector_t found_length,
	output fea_pkg::cnt_t    extent_total
);
	import fea_pkg::*;

	state_t state_q, state_d;

	logic [2:0] op_q;
	sector_t    s_q, n_q;
	cnt_t       idx_q;
	cnt_t       used_q;
	logic       cur_q;

	// read stream
	cnt_t ra_q, ridx_s1;
	logic rv_s1, sec_q, tail_q;

	// scan results
	logic hit_q, xhit_q, front_q, back_q, rm_q, rany_q, rlt0_q;
	cnt_t k_q, kx_q, rpos_q;

	// decided edit
	act_t       act_q;
	cnt_t       ak_q;
	logic       mrg_q;
	logic [1:0] st_q;
	sector_t    fs_q, fl_q;

	// edited item and merge accumulator
	logic    em_v_s2;
	sector_t em_s_s2, em_l_s2;
	logic    acc_v_q;
	sector_t acc_s_q, acc_l_q;
	cnt_t    wp_q;

	// output register
	logic       out_v_q;
	logic [1:0] out_st_q;
	sector_t    out_fs_q, out_fl_q;
	cnt_t       out_tot_q;

	// RAM ports
	logic   rd_en, wr_en, wr_bank;
	addr_t  rd_addr, wr_addr;
	entry_t wr_dat, rd_dat0, rd_dat1, rd_dat;

	// combinational helpers
	sector_t              d_s, d_l;
	logic [SECTOR_BITS:0] re_end, d_end, acc_end, acc_sum;
	logic                 stream_more, stall_rd, tail_emit, em_v, join_w, scan_done, rwr_done;
	logic                 tail_pend, resp_load;
	sector_t              em_s, em_l, sat_l;

	act_t       dec_act;
	cnt_t       dec_k;
	logic       dec_mrg, dec_rwr, ap_ok;
	logic [1:0] dec_st;

	// two banks; a rewrite pass reads one and writes the other
	fea_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_bank0 (
		.clk   (clk),
		.we    (wr_en && !wr_bank),
		.waddr (wr_addr),
		.wdata (wr_dat),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_dat0)
	);

	fea_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_bank1 (
		.clk   (clk),
		.we    (wr_en && wr_bank),
		.waddr (wr_addr),
		.wdata (wr_dat),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_dat1)
	);

	// split read data and form range ends
	always_comb begin
		rd_dat      = cur_q ? rd_dat1 : rd_dat0;
		d_s         = rd_dat[ENTRY_W-1:SECTOR_BITS];
		d_l         = rd_dat[SECTOR_BITS-1:0];
		re_end      = {1'b0, s_q} + {1'b0, n_q};
		d_end       = {1'b0, d_s} + {1'b0, d_l};
		acc_end     = {1'b0, acc_s_q} + {1'b0, acc_l_q};
		acc_sum     = {1'b0, acc_l_q} + {1'b0, em_l_s2};
		sat_l       = acc_sum[SECTOR_BITS] ? '1 : acc_sum[SECTOR_BITS-1:0];
		join_w      = mrg_q && acc_v_q && (acc_end == {1'b0, em_s_s2});
		stream_more = ra_q < used_q;
		tail_pend   = (act_q == ACT_INSERT) && (ak_q == used_q) && !tail_q;
		scan_done   = !rv_s1 && !stream_more;
		ap_ok       = (s_q != '0) && (n_q != '0) && (used_q < cnt_t'(MAX_EXTENTS));
		resp_load   = !out_v_q || !out_stall;
	end

	// decide the edit from the scan results
	always_comb begin
		dec_act = ACT_NONE;
		dec_k   = k_q;
		dec_mrg = 1'b0;
		dec_rwr = 1'b0;
		dec_st  = ST_OK;
		unique case (op_q)
			OP_FIND: begin
				dec_st = hit_q ? ST_OK : ST_NOMATCH;
			end
			OP_OCCUPY: begin
				if (hit_q) begin
					dec_rwr = 1'b1;
					dec_act = rm_q ? ACT_REMOVE : ACT_FRONT;
				end else begin
					dec_st = ST_NOMATCH;
				end
			end
			OP_CLAIM: begin
				dec_rwr = 1'b1;
				if (xhit_q) begin
					dec_act = ACT_REMOVE;
					dec_k   = kx_q;
				end else begin
					dec_mrg = 1'b1;
					if (hit_q) begin
						priority if (front_q) begin
							dec_act = ACT_FRONT;
						end else if (back_q) begin
							dec_act = ACT_BACK;
						end else if (used_q >= cnt_t'(MAX_EXTENTS)) begin
							dec_st = ST_FULL;
						end else begin
							dec_act = ACT_SPLIT;
						end
					end else begin
						dec_st = ST_NOMATCH;
					end
				end
			end
			OP_RELEASE: begin
				if (used_q >= cnt_t'(MAX_EXTENTS)) begin
					dec_st = ST_FULL;
				end else begin
					dec_rwr = 1'b1;
					dec_mrg = 1'b1;
					dec_act = ACT_INSERT;
					priority if (used_q == '0 || rlt0_q) begin
						dec_k = '0;
					end else if (rany_q) begin
						dec_k = rpos_q + cnt_t'(1);
					end else begin
						dec_k = cnt_t'(1);
					end
				end
			end
			OP_APPEND: begin
				if (s_q != '0 && n_q != '0 && used_q >= cnt_t'(MAX_EXTENTS)) begin
					dec_st = ST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (opcode)
						OP_FIND, OP_OCCUPY, OP_CLAIM, OP_RELEASE: state_d = S_SCAN;
						OP_READ: state_d = S_RDENT;
						default: state_d = S_DECIDE;
					endcase
				end
			end
			S_SCAN:   if (scan_done) state_d = S_DECIDE;
			S_DECIDE: state_d = dec_rwr ? S_RWR : S_RESP;
			S_RWR:    if (rwr_done) state_d = S_FLUSH;
			S_FLUSH:  if (!em_v_s2) state_d = S_RESP;
			S_RESP:   if (resp_load) state_d = S_IDLE;
			S_RDENT:  state_d = S_RDWAIT;
			S_RDWAIT: state_d = S_RESP;
			default:  state_d = S_IDLE;
		endcase
	end

	// read addressing, edit stage and write port
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = ra_q[AW-1:0];
		wr_en     = 1'b0;
		wr_bank   = !cur_q;
		wr_addr   = wp_q[AW-1:0];
		wr_dat    = {acc_s_q, acc_l_q};
		em_v      = 1'b0;
		em_s      = d_s;
		em_l      = d_l;
		stall_rd  = 1'b0;
		tail_emit = 1'b0;
		rwr_done  = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				rd_en = stream_more;
			end
			S_RDENT: begin
				rd_en   = idx_q < used_q;
				rd_addr = idx_q[AW-1:0];
			end
			S_DECIDE: begin
				// append goes straight into the active bank
				if (op_q == OP_APPEND && ap_ok) begin
					wr_en   = 1'b1;
					wr_bank = cur_q;
					wr_addr = used_q[AW-1:0];
					wr_dat  = {s_q, n_q};
				end
			end
			S_RWR: begin
				if (rv_s1) begin
					em_v = 1'b1;
					if (ridx_s1 == ak_q) begin
						unique case (act_q)
							ACT_NONE: begin
							end
							ACT_REMOVE: em_v = 1'b0;
							ACT_FRONT: begin
								em_s = re_end[SECTOR_BITS-1:0];
								em_l = d_l - n_q;
							end
							ACT_BACK: begin
								em_l = d_l - n_q;
							end
							ACT_SPLIT: begin
								if (!sec_q) begin
									em_l     = s_q - d_s;
									stall_rd = 1'b1;
								end else begin
									em_s = re_end[SECTOR_BITS-1:0];
									em_l = sector_t'(d_end - re_end);
								end
							end
							ACT_INSERT: begin
								if (!sec_q) begin
									em_s     = s_q;
									em_l     = n_q;
									stall_rd = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end else if (!stream_more && tail_pend) begin
					em_v      = 1'b1;
					em_s      = s_q;
					em_l      = n_q;
					tail_emit = 1'b1;
				end
				rwr_done = !rv_s1 && !stream_more && !tail_pend;
				// re-read the same entry while it yields two items
				if (stall_rd) begin
					rd_en   = 1'b1;
					rd_addr = ridx_s1[AW-1:0];
				end else begin
					rd_en = stream_more;
				end
				if (em_v_s2 && !join_w && acc_v_q) begin
					wr_en = 1'b1;
				end
			end
			S_FLUSH: begin
				if (em_v_s2) begin
					wr_en = !join_w && acc_v_q;
				end else begin
					wr_en = acc_v_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer registers and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_CLEAR;
			s_q       <= '0;
			n_q       <= '0;
			idx_q     <= '0;
			used_q    <= '0;
			cur_q     <= 1'b0;
			ra_q      <= '0;
			ridx_s1   <= '0;
			rv_s1     <= 1'b0;
			sec_q     <= 1'b0;
			tail_q    <= 1'b0;
			hit_q     <= 1'b0;
			xhit_q    <= 1'b0;
			front_q   <= 1'b0;
			back_q    <= 1'b0;
			rm_q      <= 1'b0;
			rany_q    <= 1'b0;
			rlt0_q    <= 1'b0;
			k_q       <= '0;
			kx_q      <= '0;
			rpos_q    <= '0;
			act_q     <= ACT_NONE;
			ak_q      <= '0;
			mrg_q     <= 1'b0;
			st_q      <= ST_OK;
			fs_q      <= '0;
			fl_q      <= '0;
			em_v_s2   <= 1'b0;
			em_s_s2   <= '0;
			em_l_s2   <= '0;
			acc_v_q   <= 1'b0;
			acc_s_q   <= '0;
			acc_l_q   <= '0;
			wp_q      <= '0;
			out_v_q   <= 1'b0;
			out_st_q  <= ST_OK;
			out_fs_q  <= '0;
			out_fl_q  <= '0;
			out_tot_q <= '0;
		end else begin
			state_q <= state_d;
			em_v_s2 <= em_v;
			em_s_s2 <= em_s;
			em_l_s2 <= em_l;

			// load a new result, or drop the held one once transferred
			if (state_q == S_RESP && resp_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					// latch the request and clear scan state
					if (in_valid) begin
						op_q    <= opcode;
						s_q     <= start_sector;
						n_q     <= sector_count;
						idx_q   <= entry_index;
						ra_q    <= '0;
						rv_s1   <= 1'b0;
						hit_q   <= 1'b0;
						xhit_q  <= 1'b0;
						rany_q  <= 1'b0;
						rlt0_q  <= 1'b0;
						fs_q    <= '0;
						fl_q    <= '0;
					end
				end
				S_SCAN: begin
					rv_s1   <= rd_en;
					ridx_s1 <= ra_q;
					if (rd_en) begin
						ra_q <= ra_q + cnt_t'(1);
					end
					if (rv_s1) begin
						unique case (op_q)
							OP_FIND: begin
								if (!hit_q && d_l >= n_q) begin
									hit_q <= 1'b1;
									fs_q  <= d_s;
									fl_q  <= d_l;
								end
							end
							OP_OCCUPY: begin
								if (!hit_q && d_s == s_q) begin
									hit_q <= 1'b1;
									k_q   <= ridx_s1;
									rm_q  <= n_q >= d_l;
								end
							end
							OP_CLAIM: begin
								if (!xhit_q && d_s == s_q && d_l == n_q) begin
									xhit_q <= 1'b1;
									kx_q   <= ridx_s1;
								end
								if (!hit_q && d_s <= s_q && d_end >= re_end) begin
									hit_q   <= 1'b1;
									k_q     <= ridx_s1;
									front_q <= d_s == s_q;
									back_q  <= d_end == re_end;
								end
							end
							OP_RELEASE: begin
								if (d_s < s_q) begin
									rany_q <= 1'b1;
									rpos_q <= ridx_s1;
								end
								if (ridx_s1 == '0) begin
									rlt0_q <= s_q < d_s;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DECIDE: begin
					act_q   <= dec_act;
					ak_q    <= dec_k;
					mrg_q   <= dec_mrg;
					st_q    <= dec_st;
					ra_q    <= '0;
					rv_s1   <= 1'b0;
					sec_q   <= 1'b0;
					tail_q  <= 1'b0;
					acc_v_q <= 1'b0;
					wp_q    <= '0;
					if (op_q == OP_CLEAR) begin
						used_q <= '0;
					end else if (op_q == OP_APPEND && ap_ok) begin
						used_q <= used_q + cnt_t'(1);
					end
				end
				S_RWR, S_FLUSH: begin
					if (state_q == S_RWR) begin
						sec_q  <= stall_rd;
						tail_q <= tail_q | tail_emit;
						if (stall_rd) begin
							rv_s1 <= 1'b1;
						end else begin
							rv_s1   <= rd_en;
							ridx_s1 <= ra_q;
							if (rd_en) begin
								ra_q <= ra_q + cnt_t'(1);
							end
						end
					end
					// merge the edited stream into the accumulator
					if (em_v_s2) begin
						if (join_w) begin
							acc_l_q <= sat_l;
						end else begin
							acc_v_q <= 1'b1;
							acc_s_q <= em_s_s2;
							acc_l_q <= em_l_s2;
							if (acc_v_q) begin
								wp_q <= wp_q + cnt_t'(1);
							end
						end
					end else if (state_q == S_FLUSH) begin
						// last entry written: swap banks
						used_q <= wp_q + cnt_t'(acc_v_q);
						cur_q  <= !cur_q;
					end
				end
				S_RDWAIT: begin
					if (idx_q < used_q) begin
						st_q <= ST_OK;
						fs_q <= d_s;
						fl_q <= d_l;
					end else begin
						st_q <= ST_INDEX;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						out_st_q  <= st_q;
						out_fs_q  <= fs_q;
						out_fl_q  <= fl_q;
						out_tot_q <= used_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = out_v_q;
	assign status       = out_st_q;
	assign found_start  = out_fs_q;
	assign found_length = out_fl_q;
	assign extent_total = out_tot_q;

endmodule

>>> dv/tb_free_extent_allocator_top.sv
// Self-checking testbench for the free extent allocator top level.
module tb_free_extent_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fea_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 400;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [2:0] OP_NOP = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		sector_t    s;
		sector_t    n;
		logic [7:0] idx;
	} request_t;

	typedef struct packed {
		logic [1:0] st;
		sector_t    fs;
		sector_t    fl;
		cnt_t       tot;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	sector_t start_sector = '0;
	sector_t sector_count = '0;
	logic [7:0] entry_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	sector_t found_start;
	sector_t found_length;
	cnt_t extent_total;

	free_extent_allocator_top dut (.*);

	always #2 clk = ~clk;

	// shadow extent table
	logic [31:0] tab_start [MAX_EXTENTS+1];
	logic [31:0] tab_len   [MAX_EXTENTS+1];
	int unsigned tab_used = 0;

	request_t pending_reqs[$];
	answer_t  awaited_answers[$];
	int unsigned failures = 0;
	int unsigned cycles = 0;
	bit hold_output = 1'b0;
	bit sender_pause = 1'b0;

	// add a request at the back of the pending queue
	function automatic void queue_request(request_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	function automatic void drop_entry(int unsigned pos);
		for (int unsigned i = pos; i + 1 < tab_used; i++) begin
			tab_start[i] = tab_start[i+1];
			tab_len[i]   = tab_len[i+1];
		end
		if (tab_used > 0) tab_used--;
	endfunction

	function automatic void place_entry(int unsigned pos, logic [31:0] s, logic [31:0] l);
		for (int unsigned i = tab_used; i > pos; i--) begin
			tab_start[i] = tab_start[i-1];
			tab_len[i]   = tab_len[i-1];
		end
		tab_start[pos] = s;
		tab_len[pos]   = l;
		tab_used++;
	endfunction

	function automatic void coalesce();
		int unsigned i;
		logic [63:0] e, nl;
		i = 1;
		while (i < tab_used) begin
			e = 64'(tab_start[i-1]) + tab_len[i-1];
			if (e == 64'(tab_start[i])) begin
				nl = 64'(tab_len[i-1]) + tab_len[i];
				if (nl > 64'hFFFFFF) nl = 64'hFFFFFF;
				tab_len[i-1] = nl[31:0];
				drop_entry(i);
			end else i++;
		end
	endfunction

	// apply one operation to the shadow table and return its answer
	function automatic answer_t allocate_step(request_t r);
		answer_t a;
		logic [31:0] s, n;
		logic [63:0] es, ee, re;
		int unsigned pos;
		bit hit;
		a = '0;
		s = 32'(r.s);
		n = 32'(r.n);
		case (r.op)
			OP_CLEAR: tab_used = 0;
			OP_APPEND: if (s != 0 && n != 0) begin
				if (tab_used >= MAX_EXTENTS) a.st = ST_FULL;
				else place_entry(tab_used, s, n);
			end
			OP_FIND: begin
				a.st = ST_NOMATCH;
				for (int unsigned i = 0; i < tab_used; i++)
					if (tab_len[i] >= n) begin
						a.fs = tab_start[i][23:0];
						a.fl = tab_len[i][23:0];
						a.st = ST_OK;
						break;
					end
			end
			OP_OCCUPY: begin
				a.st = ST_NOMATCH;
				for (int unsigned i = 0; i < tab_used; i++)
					if (tab_start[i] == s) begin
						a.st = ST_OK;
						if (n >= tab_len[i]) drop_entry(i);
						else begin
							tab_start[i] = 32'(24'(s + n));
							tab_len[i]   = tab_len[i] - n;
						end
						break;
					end
			end
			OP_CLAIM: begin
				hit = 1'b0;
				for (int unsigned i = 0; i < tab_used; i++)
					if (tab_start[i] == s && tab_len[i] == n) begin
						drop_entry(i);
						hit = 1'b1;
						break;
					end
				if (!hit) begin
					a.st = ST_NOMATCH;
					re = 64'(s) + n;
					for (int unsigned i = 0; i < tab_used; i++) begin
						es = 64'(tab_start[i]);
						ee = es + tab_len[i];
						if (es <= s && ee >= re) begin
							a.st = ST_OK;
							if (es == s) begin
								tab_start[i] = 32'(re[23:0]);
								tab_len[i]   = tab_len[i] - n;
							end else if (ee == re) tab_len[i] = tab_len[i] - n;
							else if (tab_used >= MAX_EXTENTS) a.st = ST_FULL;
							else begin
								tab_len[i] = s - es[31:0];
								place_entry(i + 1, 32'(re[23:0]), 32'(ee - re));
							end
							break;
						end
					end
					coalesce();
				end
			end
			OP_RELEASE: begin
				if (tab_used >= MAX_EXTENTS) a.st = ST_FULL;
				else begin
					if (tab_used == 0 || s < tab_start[0]) place_entry(0, s, n);
					else begin
						pos = 0;
						for (int unsigned i = 0; i < tab_used; i++)
							if (tab_start[i] < s) pos = i;
						place_entry(pos + 1, s, n);
					end
					coalesce();
				end
			end
			OP_READ: if (r.idx < tab_used) begin
				a.fs = tab_start[r.idx][23:0];
				a.fl = tab_len[r.idx][23:0];
			end else a.st = ST_INDEX;
			default: ;
		endcase
		a.tot = cnt_t'(tab_used);
		return a;
	endfunction

	// drive requests with random gaps
	int unsigned send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				awaited_answers.insert(awaited_answers.size(),
					allocate_step(pending_reqs.pop_front()));
				send_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap == 0 && !sender_pause && pending_reqs.size() > 0) begin
					in_valid     <= 1'b1;
					opcode       <= pending_reqs[0].op;
					start_sector <= pending_reqs[0].s;
					sector_count <= pending_reqs[0].n;
					entry_index  <= pending_reqs[0].idx;
				end else begin
					in_valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end
			end
		end
	end

	// check each result transfer and draw the next stall
	int unsigned recv_gap = 0;
	int unsigned hold_count = 0;
	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_answers.size() == 0) begin
					$error("result with nothing expected");
					failures++;
				end else begin
					exp_a = awaited_answers.pop_front();
					if (status !== exp_a.st) begin
						$error("status exp %0d got %0d", exp_a.st, status); failures++;
					end
					if (found_start !== exp_a.fs) begin
						$error("found_start exp %0h got %0h", exp_a.fs, found_start); failures++;
					end
					if (found_length !== exp_a.fl) begin
						$error("found_length exp %0h got %0h", exp_a.fl, found_length);
						failures++;
					end
					if (extent_total !== exp_a.tot) begin
						$error("extent_total exp %0d got %0d", exp_a.tot, extent_total);
						failures++;
					end
				end
				recv_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) recv_gap = 0;
			end
			// hold off for a long stretch when asked, counting the cycles here
			if (hold_output) begin
				out_stall <= 1'b1;
				hold_count++;
				if (hold_count >= HOLD_CYCLES) begin
					hold_output = 1'b0;
					hold_count  = 0;
				end
			end else if (recv_gap > 0) begin
				out_stall <= 1'b1;
				recv_gap--;
			end else out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic request_t make_req(logic [2:0] op, sector_t s, sector_t n, logic [7:0] idx);
		request_t r;
		r.op = op; r.s = s; r.n = n; r.idx = idx;
		return r;
	endfunction

	// random request biased towards sectors near existing extents
	function automatic request_t random_req();
		request_t r;
		int unsigned k;
		r.op  = 3'($urandom_range(0, 7));
		k = $urandom_range(0, 99);
		if (k < 3) r.op = OP_CLEAR;
		else if (k < 20) r.op = OP_RELEASE;
		else if (k < 35) r.op = OP_APPEND;
		else if (k < 50) r.op = OP_CLAIM;
		else if (k < 62) r.op = OP_OCCUPY;
		else if (k < 75) r.op = OP_FIND;
		else if (k < 90) r.op = OP_READ;
		else if (r.op == OP_CLEAR) r.op = OP_NOP;
		r.s = sector_t'($urandom_range(0, 4000));
		r.n = sector_t'($urandom_range(0, 60));
		r.idx = 8'($urandom_range(0, 90));
		if ($urandom_range(0, 9) == 0) r.s = sector_t'($urandom);
		if ($urandom_range(0, 9) == 0) r.n = sector_t'($urandom);
		if ($urandom_range(0, 19) == 0) r.idx = 8'($urandom);
		if ((r.op == OP_OCCUPY || r.op == OP_CLAIM) && tab_used > 0
				&& $urandom_range(0, 2) != 0) begin
			k = $urandom_range(0, tab_used - 1);
			r.s = tab_start[k][23:0] + sector_t'($urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0) r.n = tab_len[k][23:0];
		end
		return r;
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || awaited_answers.size() > 0) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every opcode, edge cases
		queue_request(make_req(OP_READ, '0, '0, 8'd0));
		queue_request(make_req(OP_FIND, '0, '0, '0));
		queue_request(make_req(OP_APPEND, '0, 24'd5, '0));
		queue_request(make_req(OP_APPEND, 24'd5, '0, '0));
		queue_request(make_req(OP_APPEND, 24'd100, 24'd50, '0));
		queue_request(make_req(OP_RELEASE, 24'd150, 24'd10, '0));
		queue_request(make_req(OP_RELEASE, 24'd10, 24'd5, '0));
		queue_request(make_req(OP_RELEASE, 24'hFFFFF0, 24'hFFFFFF, '0));
		queue_request(make_req(OP_RELEASE, 24'hFFFFFF, 24'hFFFFFF, '0));
		queue_request(make_req(OP_FIND, '0, 24'd20, '0));
		queue_request(make_req(OP_FIND, '0, 24'hFFFFFF, '0));
		queue_request(make_req(OP_CLAIM, 24'd10, 24'd5, '0));
		queue_request(make_req(OP_CLAIM, 24'd120, 24'd10, '0));
		queue_request(make_req(OP_CLAIM, 24'd100, 24'd5, '0));
		queue_request(make_req(OP_CLAIM, 24'd150, 24'd10, '0));
		queue_request(make_req(OP_CLAIM, 24'd3, 24'd1, '0));
		queue_request(make_req(OP_OCCUPY, 24'hFFFFF0, 24'h20, '0));
		queue_request(make_req(OP_OCCUPY, 24'd105, 24'hFFFFFF, '0));
		queue_request(make_req(OP_OCCUPY, 24'd7, 24'd1, '0));
		queue_request(make_req(OP_READ, '0, '0, 8'd0));
		queue_request(make_req(OP_READ, '0, '0, 8'hFF));
		queue_request(make_req(OP_NOP, 24'hFFFFFF, 24'hFFFFFF, 8'hFF));
		queue_request(make_req(OP_CLEAR, '0, '0, '0));
		drain();

		// fill to full, then split and release while full; hold the output meanwhile
		hold_output = 1'b1;
		for (int i = 0; i < MAX_EXTENTS + 2; i++)
			queue_request(make_req(OP_APPEND, sector_t'(100 * i + 100), 24'd50, '0));
		wait (hold_output == 1'b0);
		queue_request(make_req(OP_CLAIM, 24'd110, 24'd10, '0));
		queue_request(make_req(OP_RELEASE, 24'd50, 24'd10, '0));
		queue_request(make_req(OP_CLAIM, 24'd100, 24'd10, '0));
		queue_request(make_req(OP_READ, '0, '0, 8'd81));
		drain();

		// random traffic, with a sender pause in the middle
		for (int i = 0; i < 600; i++) begin
			queue_request(random_req());
			if (i == 300) begin
				drain();
				sender_pause = 1'b1;
				repeat (20) @(posedge clk);
				sender_pause = 1'b0;
			end
			while (pending_reqs.size() > 0) @(posedge clk);
		end
		drain();
		repeat (SETTLE) @(posedge clk);
		if (failures == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
